// File: hw/rtl/assert_macros.svh
// assertion helpers used by the bound property checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/cnaa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cnaa_pkg;

    localparam logic [1:0] OP_POWER_ON = 2'd0;
    localparam logic [1:0] OP_CONFLICT = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_FRAME    = 2'd3;

    localparam logic [1:0] REG_NODE_ID      = 2'd0;
    localparam logic [1:0] REG_STORED_ALIAS = 2'd1;
    localparam logic [1:0] REG_WAIT_TICKS   = 2'd2;

    localparam logic KIND_CLAIM = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [1:0] GRP_LAST = 2'd3;

    localparam logic [47:0] NODE_ID_RESET      = 48'h0;
    localparam logic [15:0] STORED_ALIAS_RESET = 16'hFFFF;
    localparam logic [7:0]  WAIT_TICKS_RESET   = 8'd10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] seen_alias;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_type;
        logic [11:0] source_alias;
        logic        save_request;
        logic        last;
    } t_out_item;

    // work handed from the front to the back
    typedef struct packed {
        logic        is_done;
        logic [11:0] alias_val;
        logic        save;
    } t_job;

    // queue status seen by its neighbours
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

`default_nettype wire

// File: hw/rtl/can_node_alias_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// CAN node alias allocator. Power on, late conflict, tick and frame-seen requests are taken
// one per cycle while the job queue has room; a request that starts a claim yields four claim
// frames, shown back to back while the receiver is ready, and the tick that ends the wait
// yields one done result; the single output register shows one result at a time. A request's
// first result passes through the queue, written at the edge that takes the request, and then
// the output register, which loads it once it is free. Other ticks and ignored frames give no
// result. The seed advance (seed*513 plus constant, full 48-bit carry) and the alias fold are
// done in the cycle the request is taken. Configuration writes are taken every cycle; write
// them only while no results are outstanding.

module can_node_alias_allocator_unit
    import cnaa_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    logic [47:0] r_node_id;
    logic [15:0] r_stored_alias;
    logic [7:0]  r_wait_ticks;

    t_q_status q_status;
    logic      push;
    logic      pop;
    t_job      job_in;
    t_job      job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= NODE_ID_RESET;
            r_stored_alias <= STORED_ALIAS_RESET;
            r_wait_ticks   <= WAIT_TICKS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NODE_ID:      r_node_id      <= i_cfg_data;
                REG_STORED_ALIAS: r_stored_alias <= i_cfg_data[15:0];
                REG_WAIT_TICKS:   r_wait_ticks   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cnaa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_item         (i_in_item),
        .i_node_id      (r_node_id),
        .i_stored_alias (r_stored_alias),
        .i_wait_ticks   (r_wait_ticks),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_job          (job_in)
    );

    cnaa_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_status (q_status),
        .o_job    (job_out)
    );

    cnaa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (job_out),
        .o_pop      (pop),
        .i_node_id  (r_node_id),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cnaa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cnaa_front
    import cnaa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    input  wire logic [47:0] i_node_id,
    input  wire logic [15:0] i_stored_alias,
    input  wire logic [7:0]  i_wait_ticks,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [47:0] SEED_INC = 48'h1B0CA37A4BA9;

    logic [47:0] r_seed,    n_seed;
    logic [11:0] r_alias,   n_alias;
    logic        r_waiting, n_waiting;
    logic [7:0]  r_tick,    n_tick;
    logic        r_save,    n_save;

    logic        accept;
    logic [47:0] adv_seed;
    logic [7:0]  tick_inc;
    logic [7:0]  limit;

    function automatic logic [11:0] fold_alias(input logic [47:0] s);
        return s[47:36] ^ s[35:24] ^ s[23:12] ^ s[11:0];
    endfunction

    assign o_ready  = !i_q_status.full;
    assign accept   = i_valid && o_ready;
    // seed * 513 is seed plus seed shifted by nine
    assign adv_seed = r_seed + {r_seed[38:0], 9'b0} + SEED_INC;
    assign tick_inc = r_tick + 8'd1;
    assign limit    = (i_wait_ticks == 8'd0) ? 8'd1 : i_wait_ticks;

    always_comb begin
        n_seed    = r_seed;
        n_alias   = r_alias;
        n_waiting = r_waiting;
        n_tick    = r_tick;
        n_save    = r_save;
        o_push    = 1'b0;
        o_job     = '{is_done: 1'b0, alias_val: r_alias, save: 1'b0};
        if (accept) begin
            case (i_item.opcode)
                OP_POWER_ON: begin
                    n_seed = i_node_id;
                    if (i_stored_alias == 16'h0000 || i_stored_alias == 16'hFFFF) begin
                        n_alias = fold_alias(i_node_id);
                        n_save  = 1'b1;
                    end else begin
                        n_alias = i_stored_alias[11:0];
                        n_save  = 1'b0;
                    end
                    n_waiting = 1'b1;
                    n_tick    = 8'd0;
                    o_push    = 1'b1;
                    o_job     = '{is_done: 1'b0, alias_val: n_alias, save: 1'b0};
                end
                OP_TICK: begin
                    if (r_waiting) begin
                        n_tick = tick_inc;
                        if (tick_inc >= limit) begin
                            n_waiting = 1'b0;
                            o_push    = 1'b1;
                            o_job     = '{is_done: 1'b1, alias_val: r_alias, save: r_save};
                        end
                    end
                end
                default: begin
                    // late conflict always, or a frame from our own alias while waiting
                    if (i_item.opcode == OP_CONFLICT ||
                        (r_waiting && i_item.seen_alias == r_alias)) begin
                        n_seed    = adv_seed;
                        n_alias   = fold_alias(adv_seed);
                        n_save    = 1'b1;
                        n_waiting = 1'b1;
                        n_tick    = 8'd0;
                        o_push    = 1'b1;
                        o_job     = '{is_done: 1'b0, alias_val: n_alias, save: 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_alias   <= '0;
            r_waiting <= 1'b0;
            r_tick    <= '0;
            r_save    <= 1'b0;
        end else begin
            r_seed    <= n_seed;
            r_alias   <= n_alias;
            r_waiting <= n_waiting;
            r_tick    <= n_tick;
            r_save    <= n_save;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cnaa_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cnaa_queue
    import cnaa_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_q_status  o_status,
    output t_job       o_job
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.valid = (r_count != '0);
    assign o_job          = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cnaa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cnaa_back
    import cnaa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_q_status   i_q_status,
    input  wire t_job        i_job,
    output logic             o_pop,
    input  wire logic [47:0] i_node_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_item
);

    logic       r_valid, n_valid;
    t_out_item  r_item,  n_item;
    logic [1:0] r_grp,   n_grp;
    logic       load;
    logic [11:0] id_grp;

    assign o_valid = r_valid;
    assign o_item  = r_item;
    // output register is free when empty or being taken this cycle
    assign load    = !r_valid || i_ready;

    always_comb begin
        case (r_grp)
            2'd0:    id_grp = i_node_id[47:36];
            2'd1:    id_grp = i_node_id[35:24];
            2'd2:    id_grp = i_node_id[23:12];
            default: id_grp = i_node_id[11:0];
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_grp   = r_grp;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_q_status.valid;
            if (i_q_status.valid) begin
                if (i_job.is_done) begin
                    n_item = '{kind: KIND_DONE, frame_type: 16'h0000,
                               source_alias: i_job.alias_val, save_request: i_job.save,
                               last: 1'b1};
                    o_pop  = 1'b1;
                end else begin
                    n_item = '{kind: KIND_CLAIM, frame_type: {2'b00, r_grp, id_grp},
                               source_alias: i_job.alias_val, save_request: 1'b0,
                               last: (r_grp == GRP_LAST)};
                    if (r_grp == GRP_LAST) begin
                        o_pop = 1'b1;
                        n_grp = 2'd0;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_grp   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_grp   <= n_grp;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cnaa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cnaa_props
    import cnaa_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // a done result is alone and carries no frame type
    `ASSERT_IMPLY(a_done_shape, i_clk, i_rst_n, o_out_valid && o_out_item.kind == KIND_DONE, o_out_item.last && o_out_item.frame_type == 16'h0000)

    // claim frames never ask for a save and close on group three
    `ASSERT_IMPLY(a_claim_shape, i_clk, i_rst_n, o_out_valid && o_out_item.kind == KIND_CLAIM, !o_out_item.save_request && (o_out_item.last == (o_out_item.frame_type[15:12] == 4'd3)))

    // the next claim frame follows straight away with the next group
    `ASSERT_NEXT(a_claim_burst, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_item.kind == KIND_CLAIM && !o_out_item.last, o_out_valid && o_out_item.kind == KIND_CLAIM && o_out_item.frame_type[15:12] == $past(o_out_item.frame_type[15:12]) + 4'd1)

endmodule

bind can_node_alias_allocator_unit cnaa_props u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// File: sim/cnaa_checker.sv
`timescale 1ns / 1ps

module cnaa_checker
    import cnaa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_err_count,
    output int          o_pending,
    output logic [11:0] o_alias,
    output logic        o_waiting,
    output int          o_claim_count,
    output int          o_done_count
);

    localparam logic [47:0] SEED_MUL     = 48'd513;
    localparam logic [47:0] SEED_INC     = 48'h1B0CA37A4BA9;
    localparam logic [15:0] ALIAS_EMPTY  = 16'h0000;
    localparam logic [15:0] ALIAS_ERASED = 16'hFFFF;

    logic [47:0] node_id_r;
    logic [15:0] stored_alias_r;
    logic [7:0]  wait_ticks_r;

    logic [47:0] seed;
    logic [11:0] cur_alias;
    logic        in_wait;
    logic [7:0]  tick_cnt;
    logic        save_flag;

    t_out_item   frames_due[$];
    int          errs = 0;
    int          claims = 0;
    int          dones = 0;

    function automatic logic [11:0] fold_seed(input logic [47:0] s);
        return s[11:0] ^ s[23:12] ^ s[35:24] ^ s[47:36];
    endfunction

    // four claim frames, node id sent high group first
    task automatic queue_claim_frames();
        t_out_item f;
        for (int g = 0; g < 4; g++) begin
            f.kind         = KIND_CLAIM;
            f.frame_type   = {g[3:0], node_id_r[47 - 12 * g -: 12]};
            f.source_alias = cur_alias;
            f.save_request = 1'b0;
            f.last         = (g[1:0] == GRP_LAST);
            frames_due.push_back(f);
        end
        in_wait  = 1'b1;
        tick_cnt = 8'd0;
        claims  += 4;
    endtask

    task automatic reclaim();
        seed      = seed * SEED_MUL + SEED_INC;
        cur_alias = fold_seed(seed);
        save_flag = 1'b1;
        queue_claim_frames();
    endtask

    task automatic take_request(input t_in_item req);
        t_out_item  fin;
        logic [7:0] limit;
        case (req.opcode)
            OP_POWER_ON: begin
                seed = node_id_r;
                if (stored_alias_r == ALIAS_EMPTY || stored_alias_r == ALIAS_ERASED) begin
                    cur_alias = fold_seed(seed);
                    save_flag = 1'b1;
                end else begin
                    cur_alias = stored_alias_r[11:0];
                    save_flag = 1'b0;
                end
                queue_claim_frames();
            end
            OP_CONFLICT: begin
                reclaim();
            end
            OP_TICK: begin
                // a zero wait ends at the first tick
                limit = (wait_ticks_r == 8'd0) ? 8'd1 : wait_ticks_r;
                if (in_wait) begin
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt >= limit) begin
                        in_wait          = 1'b0;
                        fin.kind         = KIND_DONE;
                        fin.frame_type   = '0;
                        fin.source_alias = cur_alias;
                        fin.save_request = save_flag;
                        fin.last         = 1'b1;
                        frames_due.push_back(fin);
                        dones++;
                    end
                end
            end
            OP_FRAME: begin
                if (in_wait && req.seen_alias == cur_alias)
                    reclaim();
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (frames_due.size() == 0) begin
            $error("result with nothing outstanding: 0x%0h", got);
            errs++;
        end else begin
            want = frames_due.pop_front();
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("frame_type", want.frame_type, got.frame_type);
            check_field("source_alias", 16'(want.source_alias), 16'(got.source_alias));
            check_field("save_request", 16'(want.save_request), 16'(got.save_request));
            check_field("last", 16'(want.last), 16'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_id_r      = NODE_ID_RESET;
            stored_alias_r = STORED_ALIAS_RESET;
            wait_ticks_r   = WAIT_TICKS_RESET;
            seed           = '0;
            cur_alias      = '0;
            in_wait        = 1'b0;
            tick_cnt       = '0;
            save_flag      = 1'b0;
            frames_due.delete();
        end else begin
            // results leave before the request taken at this edge can add any
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_NODE_ID:      node_id_r      = i_cfg_data;
                    REG_STORED_ALIAS: stored_alias_r = i_cfg_data[15:0];
                    REG_WAIT_TICKS:   wait_ticks_r   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_request(i_in_item);
        end
        o_err_count   = errs;
        o_pending     = frames_due.size();
        o_alias       = cur_alias;
        o_waiting     = in_wait;
        o_claim_count = claims;
        o_done_count  = dones;
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cnaa_pkg::*;

    localparam int RAND_REQUESTS = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 6;
    localparam int DRAIN_CYCLES  = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    int          err_count;
    int          pending;
    logic [11:0] model_alias;
    logic        model_waiting;
    int          claim_count;
    int          done_count;

    int          burst_left = 0;
    bit          steady_sender = 1'b0;
    int          requests = 0;
    int          directed_requests = 0;
    int          phases = 0;
    int          stall_cycles = 0;
    int          ready_cyc = 0;
    int          ready_mode = 0;

    can_node_alias_allocator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cnaa_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_err_count   (err_count),
        .o_pending     (pending),
        .o_alias       (model_alias),
        .o_waiting     (model_waiting),
        .o_claim_count (claim_count),
        .o_done_count  (done_count)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver: always ready, random, or one cycle in four, with the mode redrawn at random at regular intervals
    always @(negedge clk) begin
        ready_cyc++;
        if (ready_cyc % 50 == 0)
            ready_mode = $urandom_range(0, 2);
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (ready_cyc % 4 == 0);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready)
                     || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [11:0] seen);
        int gap;
        if (burst_left == 0) begin
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_item  <= '{opcode: op, seen_alias: seen};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        requests++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every result is out, then let trailing work finish
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic new_settings(input bit write_all);
        int          r;
        logic [47:0] nid;
        logic [15:0] sa;
        logic [7:0]  wt;
        if (write_all || $urandom_range(0, 1)) begin
            r   = $urandom_range(0, 9);
            nid = (r == 0) ? '0 : (r == 1) ? '1 : {16'($urandom), 32'($urandom)};
            write_reg(REG_NODE_ID, nid);
        end
        if (write_all || $urandom_range(0, 1)) begin
            r  = $urandom_range(0, 5);
            sa = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                 (r == 2) ? 16'($urandom) : 16'($urandom_range(1, 4095));
            // bits above the register are junk half the time
            write_reg(REG_STORED_ALIAS, $urandom_range(0, 1) ? {32'($urandom), sa} : {32'h0, sa});
        end
        if (write_all || $urandom_range(0, 1)) begin
            r  = $urandom_range(0, 5);
            wt = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : 8'($urandom_range(2, 6));
            write_reg(REG_WAIT_TICKS, $urandom_range(0, 1) ? {8'($urandom), 32'($urandom), wt}
                                                            : {40'h0, wt});
        end
    endtask

    // start a claim and keep ticking, with occasional disturbance, until it finishes
    task automatic claim_sequence(input logic [1:0] start_op, input int disturb_pct);
        int r;
        int n;
        send_request(start_op, 12'($urandom_range(0, 4095)));
        n = 0;
        while (model_waiting && n < 600) begin
            r = $urandom_range(0, 99);
            if (r >= disturb_pct)
                send_request(OP_TICK, 12'($urandom_range(0, 4095)));
            else if (r < disturb_pct * 2 / 7)
                send_request(OP_FRAME, model_alias);
            else if (r < disturb_pct * 4 / 7)
                send_request(OP_FRAME, model_alias ^ 12'($urandom_range(1, 4095)));
            else if (r < disturb_pct * 6 / 7)
                send_request(OP_CONFLICT, 12'($urandom_range(0, 4095)));
            else
                send_request(OP_POWER_ON, 12'($urandom_range(0, 4095)));
            n++;
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // settings straight out of reset: idle requests, conflict before power on
        send_request(OP_TICK, 12'h000);
        send_request(OP_FRAME, 12'h000);
        send_request(OP_CONFLICT, 12'hFFF);
        repeat (int'(WAIT_TICKS_RESET)) send_request(OP_TICK, 12'hFFF);
        settle();

        // all-ones node id, empty stored alias, shortest wait
        write_reg(REG_NODE_ID, '1);
        write_reg(REG_STORED_ALIAS, 48'h0);
        write_reg(REG_WAIT_TICKS, 48'd1);
        send_request(OP_POWER_ON, 12'h000);
        send_request(OP_FRAME, model_alias ^ 12'h001);
        send_request(OP_FRAME, model_alias);
        send_request(OP_TICK, 12'h000);
        settle();

        // stored alias wider than 12 bits, zero wait
        write_reg(REG_NODE_ID, 48'h123456789ABC);
        write_reg(REG_STORED_ALIAS, 48'hABCD);
        write_reg(REG_WAIT_TICKS, 48'd0);
        send_request(OP_POWER_ON, 12'h000);
        send_request(OP_TICK, 12'h000);
        settle();

        // restart during the wait, then a late conflict
        write_reg(REG_STORED_ALIAS, 48'h0FFF);
        write_reg(REG_WAIT_TICKS, 48'd2);
        send_request(OP_POWER_ON, 12'h000);
        send_request(OP_TICK, 12'h000);
        send_request(OP_POWER_ON, 12'hFFF);
        send_request(OP_CONFLICT, 12'h000);
        send_request(OP_TICK, 12'h000);
        send_request(OP_TICK, 12'h000);
        directed_requests = requests;

        while (requests - directed_requests < RAND_REQUESTS) begin
            settle();
            phases++;
            steady_sender = ($urandom_range(0, 3) == 0);
            new_settings(phases == 1);
            if ($urandom_range(0, 4) != 0)
                claim_sequence(($urandom_range(0, 4) == 0) ? OP_CONFLICT : OP_POWER_ON,
                               $urandom_range(0, 15));
            else
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
        end

        // a long wait, uninterrupted
        settle();
        phases++;
        steady_sender = 1'b0;
        write_reg(REG_WAIT_TICKS, 48'd40);
        claim_sequence(OP_POWER_ON, 0);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("%0d requests sent (%0d directed) over %0d random setting phases",
                 requests, directed_requests, phases);
        $display("%0d claim frames and %0d finish results predicted and compared",
                 claim_count, done_count);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
